/* rtl/rhc_pkg.sv */
// Package for the RGB to HSL converter: field widths, sector codes,
// pipeline payload types and the hue sector offset function.
// No dependencies.
`timescale 1ns / 1ps

package rhc_pkg;

  localparam int COMP_W  = 8;    // one colour component
  localparam int SUM_W   = 9;    // max + min
  localparam int NUM_W   = 20;   // dividend width in the divider
  localparam int DEN_W   = 9;    // divisor width, up to 256
  localparam int QUO_W   = 13;   // quotient bits, saturation reaches 4096
  localparam int HUE_W   = 13;
  localparam int SAT_W   = 13;
  localparam int LIGHT_W = 12;
  localparam int FRAC_W  = 12;   // Q0.12

  localparam int HUE_SECTOR = 960;
  localparam int HUE_FULL   = 5760;

  localparam int DIV_LANES = 2;
  localparam int LANE_SAT  = 0;
  localparam int LANE_HUE  = 1;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // Information that rides alongside the division
  typedef struct packed {
    sector_t              sector;
    logic                 neg;
    logic                 gray;
    logic [LIGHT_W-1:0]   lightness;
  } side_t;

  typedef struct packed {
    logic [NUM_W-1:0] num_sat;
    logic [NUM_W-1:0] num_hue;
    logic [DEN_W-1:0] den_sat;
    logic [DEN_W-1:0] den_hue;
    side_t            side;
  } prep_t;

  function automatic logic [HUE_W-1:0] sector_offset(input sector_t sec);
    logic [HUE_W-1:0] off;
    unique case (sec)
      SEC_RED:   off = '0;
      SEC_GREEN: off = HUE_W'(2 * HUE_SECTOR);
      SEC_BLUE:  off = HUE_W'(4 * HUE_SECTOR);
      default:   off = '0;
    endcase
    return off;
  endfunction

endpackage

/* rtl/rgb_to_hsl_converter.sv */
// RGB to HSL converter top level: front end, pipelined divider and result
// stage. Depends on rhc_pkg, rhc_prep, rhc_div_pipe and rhc_finish.
//
// Usage
//   Slave channel s_*: one RGB pixel per transfer, 8 bits per component.
//   Master channel m_*: hue (1/16 degree, 0..5759), saturation (Q0.12,
//   0..4096) and lightness (Q0.12, (max+min)*8) per transfer.
//   A gray pixel gives hue and saturation of zero.
// Throughput and structure
//   One pixel per clock while m_tready is high. A pixel passes the front
//   end, the divider stages and the result register, in that order. The
//   divider depth is set by the restoring divider, which resolves
//   DIV_BITS_PER_STAGE quotient bits in each of its stages for both the
//   saturation and the hue quotient in parallel.
// Reset and stalls
//   rst (synchronous) empties every stage; no pixel is pending afterwards.
//   When m_tready is low each stage holds its pixel and fills bubbles
//   ahead of it; s_tready drops only once every stage is occupied.
`timescale 1ns / 1ps

module rgb_to_hsl_converter import rhc_pkg::*; #(
  parameter int DIV_BITS_PER_STAGE = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // hue [12:0], saturation [25:13], lightness [37:26], zero
);

  localparam int SIDE_W = $bits(side_t);

  logic             prep_valid;
  logic             prep_ready;
  prep_t            prep_data;

  logic [NUM_W-1:0] div_num  [DIV_LANES];
  logic [DEN_W-1:0] div_den  [DIV_LANES];
  logic [QUO_W-1:0] div_quo  [DIV_LANES];
  logic [DEN_W-1:0] div_rem  [DIV_LANES];
  logic [SIDE_W-1:0] div_side;
  logic             div_valid;
  logic             div_ready;

  logic [HUE_W-1:0]   hue;
  logic [SAT_W-1:0]   saturation;
  logic [LIGHT_W-1:0] lightness;

  rhc_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .red       (s_tdata[7:0]),
    .green     (s_tdata[15:8]),
    .blue      (s_tdata[23:16]),
    .out_valid (prep_valid),
    .out_ready (prep_ready),
    .out_data  (prep_data)
  );

  assign div_num[LANE_SAT] = prep_data.num_sat;
  assign div_num[LANE_HUE] = prep_data.num_hue;
  assign div_den[LANE_SAT] = prep_data.den_sat;
  assign div_den[LANE_HUE] = prep_data.den_hue;

  rhc_div_pipe #(
    .LANES (DIV_LANES),
    .NW    (NUM_W),
    .DW    (DEN_W),
    .QW    (QUO_W),
    .SW    (SIDE_W),
    .BPS   (DIV_BITS_PER_STAGE)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .in_num    (div_num),
    .in_den    (div_den),
    .in_side   (prep_data.side),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_quo   (div_quo),
    .out_rem   (div_rem),
    .out_side  (div_side)
  );

  rhc_finish u_finish (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (div_valid),
    .in_ready   (div_ready),
    .quo_sat    (div_quo[LANE_SAT]),
    .quo_hue    (div_quo[LANE_HUE]),
    .rem_hue    (div_rem[LANE_HUE]),
    .side       (side_t'(div_side)),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .hue        (hue),
    .saturation (saturation),
    .lightness  (lightness)
  );

  assign m_tdata = {2'b00, lightness, saturation, hue};

  // an empty output register means the whole chain can take a pixel
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with an empty output");

  a_reset_empties: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid straight after reset");

endmodule

/* rtl/rhc_prep.sv */
// Front end of the converter: two register stages that find max/min, the
// sector and difference, then form dividends and divisors. Uses rhc_pkg.
`timescale 1ns / 1ps

module rhc_prep import rhc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [COMP_W-1:0] red,
  input  logic [COMP_W-1:0] green,
  input  logic [COMP_W-1:0] blue,
  output logic              out_valid,
  input  logic              out_ready,
  output prep_t             out_data
);

  typedef struct packed {
    logic [SUM_W-1:0]  p;
    logic [COMP_W-1:0] q;
    sector_t           sector;
    logic              neg;
    logic [COMP_W-1:0] dmag;
  } s1_t;

  logic  s1_valid;
  s1_t   s1;
  s1_t   s1_next;
  logic  s1_ready;
  logic  s2_ready;
  prep_t s2_next;

  assign s2_ready = !out_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  // stage 1: max, min, sector (red wins ties over green, green over blue)
  always_comb begin
    logic [COMP_W-1:0] mx;
    logic [COMP_W-1:0] mn;
    logic [COMP_W-1:0] a;
    logic [COMP_W-1:0] b;
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx)  mx = blue;
    if (green < mn) mn = green;
    if (blue < mn)  mn = blue;
    if (red >= green && red >= blue) begin
      s1_next.sector = SEC_RED;
      a = green;
      b = blue;
    end else if (green >= blue) begin
      s1_next.sector = SEC_GREEN;
      a = blue;
      b = red;
    end else begin
      s1_next.sector = SEC_BLUE;
      a = red;
      b = green;
    end
    s1_next.p    = {1'b0, mx} + {1'b0, mn};
    s1_next.q    = mx - mn;
    s1_next.neg  = a < b;
    s1_next.dmag = (a < b) ? (b - a) : (a - b);
  end

  // stage 2: dividends and divisors
  always_comb begin
    logic [17:0] d960;
    d960 = {s1.dmag, 10'd0} - {4'd0, s1.dmag, 6'd0};
    s2_next.num_sat = NUM_W'({s1.q, {FRAC_W{1'b0}}});
    s2_next.num_hue = NUM_W'(d960);
    s2_next.den_sat = s1.p[SUM_W-1] ? DEN_W'(10'd512 - {1'b0, s1.p}) : DEN_W'(s1.p);
    s2_next.den_hue = DEN_W'(s1.q);
    s2_next.side.sector    = s1.sector;
    s2_next.side.neg       = s1.neg;
    s2_next.side.gray      = (s1.q == '0);
    s2_next.side.lightness = {s1.p, 3'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= in_valid;
      if (s2_ready) out_valid <= s1_valid;
    end
    if (s1_ready && in_valid) s1 <= s1_next;
    if (s2_ready && s1_valid) out_data <= s2_next;
  end

endmodule

/* rtl/rhc_div_pipe.sv */
// Pipelined restoring divider with several lanes in lockstep and a sideband
// that travels with each transfer. Uses rhc_pkg only for the import style.
`timescale 1ns / 1ps

module rhc_div_pipe import rhc_pkg::*; #(
  parameter int LANES = 2,
  parameter int NW    = 20,
  parameter int DW    = 9,
  parameter int QW    = 13,
  parameter int SW    = 16,
  parameter int BPS   = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [NW-1:0] in_num [LANES],
  input  logic [DW-1:0] in_den [LANES],
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [QW-1:0] out_quo [LANES],
  output logic [DW-1:0] out_rem [LANES],
  output logic [SW-1:0] out_side
);

  localparam int STAGES = (QW + BPS - 1) / BPS;

  logic [STAGES:0]   rdy;
  logic [STAGES-1:0] vld;
  logic [DW-1:0]     rem_w  [STAGES][LANES];
  logic [QW-1:0]     acc_w  [STAGES][LANES];
  logic [DW-1:0]     den_w  [STAGES][LANES];
  logic [SW-1:0]     side_w [STAGES];

  logic              src_vld  [STAGES];
  logic [DW-1:0]     src_rem  [STAGES][LANES];
  logic [QW-1:0]     src_acc  [STAGES][LANES];
  logic [DW-1:0]     src_den  [STAGES][LANES];
  logic [SW-1:0]     src_side [STAGES];

  assign rdy[STAGES] = out_ready;
  assign in_ready    = rdy[0];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic          vld_r;
    logic [DW-1:0] rem_r  [LANES];
    logic [QW-1:0] acc_r  [LANES];
    logic [DW-1:0] den_r  [LANES];
    logic [SW-1:0] side_r;
    logic [DW-1:0] rem_nx [LANES];
    logic [QW-1:0] acc_nx [LANES];

    if (s == 0) begin : g_src_in
      assign src_vld[s]  = in_valid;
      assign src_side[s] = in_side;
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        // partial remainder starts as the dividend bits above the quotient
        assign src_rem[s][l] = DW'(in_num[l] >> QW);
        assign src_acc[s][l] = in_num[l][QW-1:0];
        assign src_den[s][l] = in_den[l];
      end
    end else begin : g_src_prev
      assign src_vld[s]  = vld[s-1];
      assign src_side[s] = side_w[s-1];
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign src_rem[s][l] = rem_w[s-1][l];
        assign src_acc[s][l] = acc_w[s-1][l];
        assign src_den[s][l] = den_w[s-1][l];
      end
    end

    always_comb begin
      logic [DW:0]   t;
      logic [DW-1:0] r;
      logic [QW-1:0] a;
      logic          qb;
      for (int l = 0; l < LANES; l++) begin
        r = src_rem[s][l];
        a = src_acc[s][l];
        for (int k = 0; k < BPS; k++) begin
          if (s * BPS + k < QW) begin
            t = {r, a[QW-1]};
            if (t >= {1'b0, src_den[s][l]}) begin
              r  = DW'(t - {1'b0, src_den[s][l]});
              qb = 1'b1;
            end else begin
              r  = t[DW-1:0];
              qb = 1'b0;
            end
            // dividend bits shift out at the top as quotient bits enter below
            a = {a[QW-2:0], qb};
          end
        end
        rem_nx[l] = r;
        acc_nx[l] = a;
      end
    end

    assign rdy[s] = !vld_r || rdy[s+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r <= 1'b0;
      end else if (rdy[s]) begin
        vld_r <= src_vld[s];
      end
      if (rdy[s] && src_vld[s]) begin
        side_r <= src_side[s];
        for (int l = 0; l < LANES; l++) begin
          rem_r[l] <= rem_nx[l];
          acc_r[l] <= acc_nx[l];
          den_r[l] <= src_den[s][l];
        end
      end
    end

    assign vld[s]    = vld_r;
    assign side_w[s] = side_r;
    for (genvar l = 0; l < LANES; l++) begin : g_out
      assign rem_w[s][l] = rem_r[l];
      assign acc_w[s][l] = acc_r[l];
      assign den_w[s][l] = den_r[l];
    end
  end

  assign out_valid = vld[STAGES-1];
  assign out_side  = side_w[STAGES-1];
  for (genvar l = 0; l < LANES; l++) begin : g_res
    assign out_quo[l] = acc_w[STAGES-1][l];
    assign out_rem[l] = rem_w[STAGES-1][l];
  end

  // remainder must end below a non-zero divisor
  for (genvar l = 0; l < LANES; l++) begin : g_chk
    a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
      (out_valid && den_w[STAGES-1][l] != '0) |-> (out_rem[l] < den_w[STAGES-1][l]))
      else $error("divider remainder not below divisor");
  end

endmodule

/* rtl/rhc_finish.sv */
// Back end of the converter: floors the hue quotient, adds the sector
// offset, wraps negative hue and holds the result register. Uses rhc_pkg.
`timescale 1ns / 1ps

module rhc_finish import rhc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [QUO_W-1:0]   quo_sat,
  input  logic [QUO_W-1:0]   quo_hue,
  input  logic [DEN_W-1:0]   rem_hue,
  input  side_t              side,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [HUE_W-1:0]   hue,
  output logic [SAT_W-1:0]   saturation,
  output logic [LIGHT_W-1:0] lightness
);

  logic [HUE_W-1:0] hue_next;
  logic [SAT_W-1:0] sat_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    logic        [12:0] mag;
    logic signed [13:0] off;
    logic signed [13:0] hs;
    // floor toward minus infinity: a negative difference with a remainder
    // rounds one further away from zero
    mag = quo_hue + {12'd0, side.neg && (rem_hue != '0)};
    off = $signed({1'b0, sector_offset(side.sector)});
    if (side.neg) hs = off - $signed({1'b0, mag});
    else          hs = off + $signed({1'b0, mag});
    if (hs < 0) hs = hs + 14'sd5760;
    if (side.gray) begin
      hue_next = '0;
      sat_next = '0;
    end else begin
      hue_next = hs[HUE_W-1:0];
      sat_next = quo_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      hue        <= hue_next;
      saturation <= sat_next;
      lightness  <= side.lightness;
    end
  end

  a_ranges: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hue < HUE_W'(HUE_FULL) && saturation <= SAT_W'(1 << FRAC_W)))
    else $error("hue or saturation out of range");

endmodule

/* test/rgb_to_hsl_converter_test.sv */
// Self-checking testbench for rgb_to_hsl_converter: directed and random pixels
// against an internal fixed-point HSL predictor, with random stalls on both channels.
// Depends on rhc_pkg and the rgb_to_hsl_converter RTL.
`timescale 1ns / 1ps

module rgb_to_hsl_converter_test;
  import rhc_pkg::*;

  localparam int N_RANDOM   = 1400;
  localparam int QUIET_FROM = 1150;     // no idling on either side past this item
  localparam int HOLD_AT    = 300;      // results checked before the long receiver hold
  localparam int HOLD_LEN   = 80;
  localparam int DRAIN      = 24;
  localparam int LIMIT      = 200000;

  typedef struct packed {
    logic [LIGHT_W-1:0] lightness;
    logic [SAT_W-1:0]   saturation;
    logic [HUE_W-1:0]   hue;
  } hsl_t;

  class hsl_scoreboard;
    hsl_t pending_hsl[$];
    int   mismatches;
    int   checked;

    function new();
      mismatches = 0;
      checked    = 0;
    endfunction

    // Fixed-point RGB to HSL, floored quotients throughout
    function hsl_t predict_hsl(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
      hsl_t    res;
      int      r, g, b, mx, mn, p, q, diff, den, num, h, s;
      sector_t sec;
      r = int'(red); g = int'(green); b = int'(blue);
      mx = r; mn = r; sec = SEC_RED;
      // strict compares give red priority over green, green over blue
      if (g > mx) begin mx = g; sec = SEC_GREEN; end
      if (b > mx) begin mx = b; sec = SEC_BLUE; end
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      p = mx + mn;
      q = mx - mn;
      h = 0;
      s = 0;
      if (q != 0) begin
        den = (p < 256) ? p : (512 - p);
        s = (q * 4096) / den;
        case (sec)
          SEC_RED:   begin diff = g - b; h = 0; end
          SEC_GREEN: begin diff = b - r; h = 2 * HUE_SECTOR; end
          default:   begin diff = r - g; h = 4 * HUE_SECTOR; end
        endcase
        num = HUE_SECTOR * diff;
        if (num >= 0) h = h + num / q;
        else          h = h - ((-num + q - 1) / q);
        if (h < 0) h = h + HUE_FULL;
      end
      res.hue        = HUE_W'(h);
      res.saturation = SAT_W'(s);
      res.lightness  = LIGHT_W'(p * 8);
      return res;
    endfunction

    function void note_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
      pending_hsl.push_back(predict_hsl(red, green, blue));
    endfunction

    task report_mismatch(string field, int got, int want);
      mismatches++;
      $display("%0t: %s mismatch, got %0d want %0d", $time, field, got, want);
    endtask

    task check_result(logic [39:0] data);
      hsl_t got, want;
      got = data[37:0];
      if (pending_hsl.size() == 0) begin
        report_mismatch("unexpected result, hue", int'(got.hue), -1);
        return;
      end
      want = pending_hsl.pop_front();
      checked++;
      if (got.hue != want.hue)
        report_mismatch("hue", int'(got.hue), int'(want.hue));
      if (got.saturation != want.saturation)
        report_mismatch("saturation", int'(got.saturation), int'(want.saturation));
      if (got.lightness != want.lightness)
        report_mismatch("lightness", int'(got.lightness), int'(want.lightness));
      if (data[39:38] != 2'b00) report_mismatch("pad", int'(data[39:38]), 0);
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;    // red [7:0], green [15:8], blue [23:16]
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;    // hue [12:0], saturation [25:13], lightness [37:26], zero

  hsl_scoreboard sb;
  logic          quiet;
  int            cycles;

  rgb_to_hsl_converter DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  initial begin
    clk      = 1'b0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    m_tready = 1'b0;
    quiet    = 1'b0;
    cycles   = 0;
    sb       = new();
  end

  // Offer one pixel, with an occasional gap first, and wait for its transfer
  task send_pixel(input logic [7:0] red, input logic [7:0] green, input logic [7:0] blue);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {blue, green, red};
    do @(posedge clk); while (!s_tready);
    sb.note_pixel(red, green, blue);
  endtask

  task send_random_pixel(input int idx);
    logic [7:0] a, b, c;
    int         mode;
    a = 8'($urandom_range(0, 255));
    b = 8'($urandom_range(0, 255));
    c = 8'($urandom_range(0, 255));
    mode = $urandom_range(0, 9);
    case (mode)
      0: send_pixel(a, a, a);                        // gray
      1: send_pixel(a, a, b);                        // red/green tie
      2: send_pixel(b, a, a);                        // green/blue tie
      3: send_pixel(a, b, a);                        // red/blue tie
      4: send_pixel(a[0] ? 8'd255 : 8'd0, {6'd0, b[1:0]},
                    8'd255 - {6'd0, c[1:0]});        // near the extremes
      default: send_pixel(a, b, c);
    endcase
    if (idx == QUIET_FROM) quiet = 1'b1;
  endtask

  // Stimulus and end of run
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_pixel(8'd0,   8'd0,   8'd0);     // black
    send_pixel(8'd255, 8'd255, 8'd255);   // white
    send_pixel(8'd128, 8'd128, 8'd128);   // mid gray
    send_pixel(8'd255, 8'd0,   8'd0);     // pure red
    send_pixel(8'd0,   8'd255, 8'd0);     // pure green
    send_pixel(8'd0,   8'd0,   8'd255);   // pure blue
    send_pixel(8'd255, 8'd255, 8'd0);     // red beats green on a tie
    send_pixel(8'd0,   8'd255, 8'd255);   // green beats blue on a tie
    send_pixel(8'd255, 8'd0,   8'd255);   // red beats blue on a tie
    send_pixel(8'd255, 8'd0,   8'd1);     // negative hue wraps
    send_pixel(8'd200, 8'd10,  8'd100);
    send_pixel(8'd1,   8'd0,   8'd0);     // smallest chroma, full saturation
    send_pixel(8'd255, 8'd1,   8'd1);     // sum at 256
    send_pixel(8'd255, 8'd2,   8'd2);     // sum just above 256
    send_pixel(8'd254, 8'd1,   8'd0);     // sum just below 256
    send_pixel(8'd255, 8'd254, 8'd254);   // near white, small denominator
    send_pixel(8'd0,   8'd1,   8'd255);   // blue, red below green
    send_pixel(8'd1,   8'd255, 8'd0);     // green, blue below red
    send_pixel(8'd0,   8'd255, 8'd1);
    send_pixel(8'd170, 8'd85,  8'd0);
    send_pixel(8'd1,   8'd1,   8'd0);
    for (int i = 0; i < N_RANDOM; i++) send_random_pixel(i);
    s_tvalid <= 1'b0;
    while (sb.pending_hsl.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (sb.mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // Result side: check transfers, then pick next m_tready
  initial begin
    int stall_left;
    bit held;
    stall_left = 0;
    held       = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (!held && sb.checked >= HOLD_AT) begin
        held       = 1;
        stall_left = HOLD_LEN;   // long hold so the pipe fills and s_tready drops
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

endmodule
